// ===== design/sktis_pkg.sv =====
`default_nettype none

package sktis_pkg;

    // Table geometry.
    localparam int CAPACITY = 64;
    localparam int KEEP     = 32;

    // Key and field widths.
    localparam int KEY_W   = 128;
    localparam int HALF_W  = 64;
    localparam int SPLIT_W = 7;
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int THR_W   = (CNT_W > SPLIT_W) ? CNT_W : SPLIT_W;

    // Cell that presents the first entry above the kept part.
    localparam int HEAD_IDX = (KEEP < CAPACITY) ? KEEP : CAPACITY - 1;

    typedef logic [KEY_W-1:0]   key_t;
    typedef logic [CNT_W-1:0]   count_t;
    typedef logic [SPLIT_W-1:0] split_t;
    typedef logic [THR_W-1:0]   thr_t;

    localparam split_t SPLIT_RESET = SPLIT_W'(64);
    localparam count_t KEEP_CNT    = CNT_W'(KEEP);
    localparam count_t KEEP_P1_CNT = CNT_W'(KEEP + 1);
    localparam count_t CAP_CNT     = CNT_W'(CAPACITY);
    localparam thr_t   KEEP_P1_THR = THR_W'(KEEP + 1);
    localparam thr_t   CAP_THR     = THR_W'(CAPACITY);

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DRAIN
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     occupied;
        logic     prev_less;
    } cell_ctrl_t;

    typedef enum logic {
        ST_IDLE,
        ST_SPLIT
    } state_t;

endpackage

`default_nettype wire

// ===== design/sktis_key_if.sv =====
`default_nettype none

interface sktis_key_if;
    logic                         valid;
    logic                         ready;
    logic [sktis_pkg::HALF_W-1:0] key_high;
    logic [sktis_pkg::HALF_W-1:0] key_low;

    modport source (output valid, output key_high, output key_low, input ready);
    modport sink   (input valid, input key_high, input key_low, output ready);
endinterface

`default_nettype wire

// ===== design/sktis_res_if.sv =====
`default_nettype none

interface sktis_res_if;
    logic                         valid;
    logic                         ready;
    logic                         moved;
    logic [sktis_pkg::HALF_W-1:0] out_key_high;
    logic [sktis_pkg::HALF_W-1:0] out_key_low;
    logic                         last;

    modport source (output valid, output moved, output out_key_high, output out_key_low,
                    output last, input ready);
    modport sink   (input valid, input moved, input out_key_high, input out_key_low,
                    input last, output ready);
endinterface

`default_nettype wire

// ===== design/sktis_cell.sv =====
`default_nettype none

// One table slot. It compares its key with the broadcast key and either
// holds, takes the broadcast key, takes its lower neighbor's key, or takes
// its upper neighbor's key when the upper run drains.
module sktis_cell (
    input  wire logic                  clk,
    input  wire sktis_pkg::cell_ctrl_t ctrl,
    input  wire sktis_pkg::key_t       key_in,
    input  wire sktis_pkg::key_t       key_prev,
    input  wire sktis_pkg::key_t       key_nxt,
    output sktis_pkg::key_t            key_out,
    output logic                       less
);

    sktis_pkg::key_t key_reg;
    sktis_pkg::key_t key_next;

    assign less    = ctrl.occupied && (key_reg < key_in);
    assign key_out = key_reg;

    always_comb
    begin
        key_next = key_reg;
        unique case (ctrl.op)
            sktis_pkg::CELL_HOLD:
            begin
                key_next = key_reg;
            end
            sktis_pkg::CELL_INSERT:
            begin
                if (!less)
                begin
                    key_next = ctrl.prev_less ? key_in : key_prev;
                end
            end
            sktis_pkg::CELL_DRAIN:
            begin
                key_next = key_nxt;
            end
            default:
            begin
                key_next = key_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

`default_nettype wire

// ===== design/sorted_key_table_insert_split.sv =====
// Sorted key table with insert and split. The table is a row of 64 cells that
// keeps 128-bit keys in ascending unsigned order (key_high is the more
// significant half). Each request key is compared against every cell at once,
// and in the same cycle the cells at and above its place shift up by one, so
// an ordinary insert produces one response with moved = 0.
// A request arriving at a full table that cannot split is answered with
// moved = 1 and the table unchanged. When the entry count has reached the
// split threshold (split_at, clamped to between KEEP+1 and the capacity), the table
// splits: the upper entries leave one per cycle, when the output register is free,
// through cell KEEP while the cells above shift down, followed or interleaved by
// the new key when it belongs to the moved run, or followed by its insertion into
// the kept part. A split with N entries above KEEP therefore produces N+1
// responses, paced by the output register; no new request is taken until its
// last response is loaded. The final response of every request has last = 1. The
// user must write the split threshold through cfg_we/cfg_wdata while the block is
// idle; the block itself does not enforce it. No clearing pass is needed after reset.
`default_nettype none

module sorted_key_table_insert_split (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    sktis_key_if.sink                          req,
    sktis_res_if.source                        rsp,
    input  wire logic                          cfg_we,
    input  wire logic [sktis_pkg::SPLIT_W-1:0] cfg_wdata
);

    // Cell row.
    sktis_pkg::key_t                    cell_key  [sktis_pkg::CAPACITY];
    sktis_pkg::cell_ctrl_t              cell_ctrl [sktis_pkg::CAPACITY];
    logic [sktis_pkg::CAPACITY-1:0]     cell_less;
    sktis_pkg::key_t                    bcast_key;
    sktis_pkg::key_t                    in_key;
    sktis_pkg::key_t                    head_key;
    logic                               head_less;

    // Control state.
    sktis_pkg::state_t state_reg, state_next;
    sktis_pkg::count_t count_reg, count_next;
    sktis_pkg::split_t split_at_reg, split_at_next;
    sktis_pkg::key_t   key_reg, key_next;
    logic              joins_reg, joins_next;
    logic              placed_reg, placed_next;

    // Output register.
    logic              rsp_valid_reg, rsp_valid_next;
    logic              rsp_moved_reg;
    logic              rsp_last_reg;
    sktis_pkg::key_t   rsp_key_reg;

    // Decisions made in the current cycle.
    logic              out_free;
    logic              load;
    logic              ld_moved;
    logic              ld_last;
    sktis_pkg::key_t   ld_key;
    logic              ins;
    logic              drain;
    logic              start_split;
    logic              done;
    logic              split_go;
    sktis_pkg::thr_t   split_ext;
    sktis_pkg::thr_t   thr_raised;
    sktis_pkg::thr_t   thr;

    assign in_key    = {req.key_high, req.key_low};
    assign head_key  = cell_key[sktis_pkg::HEAD_IDX];
    assign head_less = cell_less[sktis_pkg::HEAD_IDX];
    assign out_free  = !rsp_valid_reg || rsp.ready;

    // The effective threshold is split_at raised to KEEP+1, then capped at the capacity.
    assign split_ext  = sktis_pkg::THR_W'(split_at_reg);
    assign thr_raised = (split_ext < sktis_pkg::KEEP_P1_THR) ? sktis_pkg::KEEP_P1_THR
                                                             : split_ext;
    assign thr        = (thr_raised > sktis_pkg::CAP_THR) ? sktis_pkg::CAP_THR : thr_raised;
    assign split_go   = (sktis_pkg::THR_W'(count_reg) >= thr)
                        && (count_reg > sktis_pkg::KEEP_CNT);

    genvar gi;
    generate
        for (gi = 0; gi < sktis_pkg::CAPACITY; gi++)
        begin : g_cell
            sktis_pkg::key_t key_prev;
            sktis_pkg::key_t key_nxt;
            logic            prev_less;

            always_comb
            begin
                if (ins)
                begin
                    cell_ctrl[gi].op = sktis_pkg::CELL_INSERT;
                end
                else if (drain && (gi >= sktis_pkg::KEEP))
                begin
                    cell_ctrl[gi].op = sktis_pkg::CELL_DRAIN;
                end
                else
                begin
                    cell_ctrl[gi].op = sktis_pkg::CELL_HOLD;
                end
                cell_ctrl[gi].occupied  = (count_reg > sktis_pkg::CNT_W'(gi));
                cell_ctrl[gi].prev_less = prev_less;
            end

            // The lowest cell sees an imaginary smaller neighbor, so a key that is
            // not larger than any entry lands there.
            if (gi == 0)
            begin : g_first
                assign prev_less = 1'b1;
                assign key_prev  = bcast_key;
            end
            else
            begin : g_inner
                assign prev_less = cell_less[gi-1];
                assign key_prev  = cell_key[gi-1];
            end

            // The top cell has no upper neighbor; its content past the count is dead.
            if (gi == sktis_pkg::CAPACITY - 1)
            begin : g_top
                assign key_nxt = cell_key[gi];
            end
            else
            begin : g_below
                assign key_nxt = cell_key[gi+1];
            end

            sktis_cell u_cell (
                .clk      (clk),
                .ctrl     (cell_ctrl[gi]),
                .key_in   (bcast_key),
                .key_prev (key_prev),
                .key_nxt  (key_nxt),
                .key_out  (cell_key[gi]),
                .less     (cell_less[gi])
            );
        end
    endgenerate

    // Per-cycle decisions: which response to load and what the cell row does.
    always_comb
    begin
        req.ready   = 1'b0;
        bcast_key   = key_reg;
        load        = 1'b0;
        ld_moved    = 1'b0;
        ld_last     = 1'b0;
        ld_key      = head_key;
        ins         = 1'b0;
        drain       = 1'b0;
        start_split = 1'b0;
        done        = 1'b0;
        count_next  = count_reg;
        key_next    = key_reg;
        joins_next  = joins_reg;
        placed_next = placed_reg;

        unique case (state_reg)
            sktis_pkg::ST_IDLE:
            begin
                bcast_key = in_key;
                req.ready = out_free;
                if (req.valid && out_free)
                begin
                    key_next = in_key;
                    load     = 1'b1;
                    if (split_go)
                    begin
                        // The first moved response is always the entry at cell KEEP:
                        // either it is smaller than the new key, or the key stays below.
                        ld_moved    = 1'b1;
                        ld_key      = head_key;
                        drain       = 1'b1;
                        count_next  = count_reg - sktis_pkg::count_t'(1);
                        joins_next  = head_less;
                        placed_next = 1'b0;
                        start_split = 1'b1;
                    end
                    else if (count_reg >= sktis_pkg::CAP_CNT)
                    begin
                        ld_moved = 1'b1;
                        ld_key   = in_key;
                        ld_last  = 1'b1;
                    end
                    else
                    begin
                        ins        = 1'b1;
                        count_next = count_reg + sktis_pkg::count_t'(1);
                        ld_key     = in_key;
                        ld_last    = 1'b1;
                    end
                end
            end
            sktis_pkg::ST_SPLIT:
            begin
                if (out_free)
                begin
                    load = 1'b1;
                    if (count_reg > sktis_pkg::KEEP_CNT)
                    begin
                        if (joins_reg && !placed_reg && !head_less)
                        begin
                            // The new key takes its sorted place in the moved run.
                            ld_moved    = 1'b1;
                            ld_key      = key_reg;
                            placed_next = 1'b1;
                        end
                        else
                        begin
                            ld_moved   = 1'b1;
                            ld_key     = head_key;
                            drain      = 1'b1;
                            count_next = count_reg - sktis_pkg::count_t'(1);
                            ld_last    = (count_reg == sktis_pkg::KEEP_P1_CNT)
                                         && joins_reg && placed_reg;
                            done       = ld_last;
                        end
                    end
                    else if (joins_reg)
                    begin
                        // The new key is larger than every moved entry.
                        ld_moved = 1'b1;
                        ld_key   = key_reg;
                        ld_last  = 1'b1;
                        done     = 1'b1;
                    end
                    else
                    begin
                        // The new key goes into the kept part.
                        ins        = 1'b1;
                        count_next = count_reg + sktis_pkg::count_t'(1);
                        ld_key     = key_reg;
                        ld_last    = 1'b1;
                        done       = 1'b1;
                    end
                end
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sktis_pkg::ST_IDLE:
            begin
                if (start_split)
                begin
                    state_next = sktis_pkg::ST_SPLIT;
                end
            end
            sktis_pkg::ST_SPLIT:
            begin
                if (done)
                begin
                    state_next = sktis_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sktis_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        split_at_next = cfg_we ? cfg_wdata : split_at_reg;
        if (load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sktis_pkg::ST_IDLE;
            count_reg     <= '0;
            split_at_reg  <= sktis_pkg::SPLIT_RESET;
            joins_reg     <= 1'b0;
            placed_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            split_at_reg  <= split_at_next;
            joins_reg     <= joins_next;
            placed_reg    <= placed_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        if (load)
        begin
            rsp_moved_reg <= ld_moved;
            rsp_last_reg  <= ld_last;
            rsp_key_reg   <= ld_key;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.moved        = rsp_moved_reg;
    assign rsp.last         = rsp_last_reg;
    assign rsp.out_key_high = rsp_key_reg[sktis_pkg::KEY_W-1:sktis_pkg::HALF_W];
    assign rsp.out_key_low  = rsp_key_reg[sktis_pkg::HALF_W-1:0];

endmodule

`default_nettype wire

// ===== design/sktis_checker.sv =====
`default_nettype none

module sktis_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         req_valid,
    input wire logic                         req_ready,
    input wire logic                         rsp_valid,
    input wire logic                         rsp_ready,
    input wire logic                         rsp_moved,
    input wire logic                         rsp_last,
    input wire logic [sktis_pkg::HALF_W-1:0] rsp_key_high,
    input wire logic [sktis_pkg::HALF_W-1:0] rsp_key_low
);

    // A stalled response keeps its contents.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_key_high)
            && $stable(rsp_key_low) && $stable(rsp_moved) && $stable(rsp_last))
        else $error("response changed while stalled");

    // Every accepted request has a response waiting in the next cycle.
    a_req_answered: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> rsp_valid)
        else $error("accepted request produced no response");

    // While a split is still emitting, no new request is taken.
    a_split_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_last |-> !req_ready)
        else $error("request taken in the middle of a split");

    // A key stored in the table always closes its request.
    a_stored_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_moved |-> rsp_last)
        else $error("stored key response not marked last");

endmodule

bind sorted_key_table_insert_split sktis_checker u_sktis_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_moved    (rsp.moved),
    .rsp_last     (rsp.last),
    .rsp_key_high (rsp.out_key_high),
    .rsp_key_low  (rsp.out_key_low)
);

`default_nettype wire

// ===== test/tb_sorted_key_table_insert_split.sv =====
`timescale 1ns / 1ps

module tb_sorted_key_table_insert_split;
    import sktis_pkg::*;

    // The run is bounded by this many clock cycles. The slowest correct run is
    // about 200 requests. Each can drain up to 33 responses, and each response
    // can wait out a stall on the response side; the limit leaves room for all of that.
    localparam int CYCLE_LIMIT = 500_000;

    // Cycles allowed after the last expected response before the block is
    // treated as idle. A split finishes with its last response, so a few are enough.
    localparam int SETTLE_CYCLES = 4;

    // Values of the moved flag.
    localparam logic STORED = 1'b0;
    localparam logic MOVED  = 1'b1;

    // One response as the checker sees it.
    typedef struct {
        logic moved;
        key_t key;
        logic last;
    } report_t;

    // One row of the directed table. When typed is set, the response is
    // written in the row: the key is echoed back with the given flags.
    // Otherwise the response comes from the table model below.
    typedef struct {
        key_t key;
        bit   typed;
        logic exp_moved;
        logic exp_last;
    } plan_row_t;

    logic   clk = 1'b0;
    logic   rst_n;
    logic   cfg_we;
    split_t cfg_wdata;

    sktis_key_if req_if ();
    sktis_res_if rsp_if ();

    sorted_key_table_insert_split DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if),
        .rsp       (rsp_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Table model. It holds its own copy of the sorted keys, the entry count
    // and the split threshold register. For each accepted request it works
    // out the responses that the block must produce.
    // ------------------------------------------------------------------
    key_t        table_keys [CAPACITY];
    int unsigned table_count;
    split_t      split_cfg;

    report_t     fresh_reports [$];   // responses of the request just accepted
    report_t     pending_reports [$]; // responses still to come, oldest first

    int          mismatches = 0;
    int unsigned cycles = 0;
    bit          idling;
    int          ready_hold = 0;

    // Sorted insert. The new key goes before the first entry that is not
    // smaller than it, so a key equal to a stored one lands ahead of it.
    function automatic void store_key(input key_t k);
        int unsigned p;
        p = 0;
        while (p < table_count && table_keys[p] < k)
            p++;
        for (int unsigned i = table_count; i > p; i--)
            table_keys[i] = table_keys[i - 1];
        table_keys[p] = k;
        table_count++;
    endfunction

    function automatic void push_fresh(input logic mv, input key_t k);
        report_t r;
        r.moved = mv;
        r.key   = k;
        r.last  = 1'b0;
        fresh_reports.push_back(r);
    endfunction

    function automatic void predict_insert(input key_t k);
        int unsigned thr;
        bit          joins;
        bit          placed;
        fresh_reports.delete();

        // A threshold written out of range is clamped. It is raised to one
        // above the kept part and lowered to the capacity.
        thr = split_cfg;
        if (thr < KEEP + 1)
            thr = KEEP + 1;
        if (thr > CAPACITY)
            thr = CAPACITY;

        if (table_count >= thr && table_count > KEEP) begin
            // Split. Everything above the kept part leaves in order. A key
            // greater than the first leaving entry joins that run in its sorted
            // place. A key equal to it or smaller stays behind in the kept part.
            joins  = table_keys[KEEP] < k;
            placed = 1'b0;
            for (int unsigned i = KEEP; i < table_count; i++) begin
                if (joins && !placed && !(table_keys[i] < k)) begin
                    push_fresh(MOVED, k);
                    placed = 1'b1;
                end
                push_fresh(MOVED, table_keys[i]);
            end
            if (joins && !placed)
                push_fresh(MOVED, k);
            table_count = KEEP;
            if (!joins) begin
                store_key(k);
                push_fresh(STORED, k);
            end
        end else if (table_count >= CAPACITY) begin
            // A full table that cannot split bounces the key unchanged.
            push_fresh(MOVED, k);
        end else begin
            store_key(k);
            push_fresh(STORED, k);
        end

        fresh_reports[fresh_reports.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Key generator for the random part. Half of the keys are aimed at the stored
    // ones, such as copies, neighbors and the first entry of a future split,
    // so that equal keys and both outcomes of a split occur often.
    // ------------------------------------------------------------------
    function automatic key_t pick_key();
        key_t k;
        int   len;
        k = {$urandom, $urandom, $urandom, $urandom};
        case ($urandom_range(0, 11))
            4, 5:
                if (table_count > 0)
                    k = table_keys[$urandom_range(0, table_count - 1)];
            6:
                if (table_count > KEEP)
                    k = table_keys[KEEP];
            7:
                if (table_count > KEEP)
                    k = $urandom_range(0, 1) ? table_keys[KEEP] + 1 : table_keys[KEEP] - 1;
            8:
                if (table_count > 0)
                    k = table_keys[table_count - 1] + key_t'($urandom_range(0, 2));
            9:
                if (table_count > 0)
                    k[127:64] = table_keys[$urandom_range(0, table_count - 1)][127:64];
            10:
            begin
                // Short lowercase string, zero padded after its end.
                k   = '0;
                len = $urandom_range(1, 16);
                for (int b = 0; b < len; b++)
                    k[127 - 8 * b -: 8] = 8'($urandom_range(97, 122));
            end
            default:
                ;
        endcase
        return k;
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting and response checking.
    // ------------------------------------------------------------------
    task automatic note_mismatch(input string what);
        $display("ERROR at %0t: %s", $time, what);
        mismatches++;
    endtask

    // A response is taken at a rising edge with valid and ready both high. It
    // is compared field by field against the oldest pending expectation.
    always @(posedge clk)
    begin : check_results
        report_t want;
        if (rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (pending_reports.size() == 0) begin
                note_mismatch($sformatf("response with nothing pending: moved %b key %h_%h",
                                        rsp_if.moved, rsp_if.out_key_high, rsp_if.out_key_low));
            end else begin
                want = pending_reports.pop_front();
                if (rsp_if.moved !== want.moved)
                    note_mismatch($sformatf("moved %b, expected %b (key %h)",
                                            rsp_if.moved, want.moved, want.key));
                if (rsp_if.out_key_high !== want.key[127:64])
                    note_mismatch($sformatf("out_key_high %h, expected %h",
                                            rsp_if.out_key_high, want.key[127:64]));
                if (rsp_if.out_key_low !== want.key[63:0])
                    note_mismatch($sformatf("out_key_low %h, expected %h",
                                            rsp_if.out_key_low, want.key[63:0]));
                if (rsp_if.last !== want.last)
                    note_mismatch($sformatf("last %b, expected %b (key %h)",
                                            rsp_if.last, want.last, want.key));
            end
        end
    end

    // The cycle counter ends a run that hangs.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // The response side stalls in random bursts while idling is on, and is
    // always ready once it is off.
    always @(negedge clk)
    begin
        if (!idling) begin
            rsp_if.ready <= 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            rsp_if.ready <= 1'b0;
            ready_hold   <= $urandom_range(1, 15) - 1;
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Request driving. Inputs change on the falling edge. A request counts as
    // taken at the rising edge where ready is seen high, and the model runs
    // right then.
    // ------------------------------------------------------------------
    task automatic send_key(input key_t k, input bit typed, input logic exp_moved,
                            input logic exp_last);
        report_t r;
        int      gap;
        @(negedge clk);
        if (idling && $urandom_range(0, 3) == 0) begin
            // Idle gap. The bus carries junk while valid is low.
            gap = $urandom_range(1, 15);
            req_if.valid    <= 1'b0;
            req_if.key_high <= {$urandom, $urandom};
            req_if.key_low  <= {$urandom, $urandom};
            repeat (gap) @(negedge clk);
        end
        req_if.valid    <= 1'b1;
        req_if.key_high <= k[127:64];
        req_if.key_low  <= k[63:0];
        do
            @(posedge clk);
        while (req_if.ready !== 1'b1);

        predict_insert(k);
        if (typed) begin
            r.moved = exp_moved;
            r.key   = k;
            r.last  = exp_last;
            pending_reports.push_back(r);
        end else begin
            foreach (fresh_reports[i])
                pending_reports.push_back(fresh_reports[i]);
        end
    endtask

    task automatic send_random(input int n);
        repeat (n) send_key(pick_key(), 1'b0, STORED, 1'b0);
    endtask

    // Drop valid and wait until every pending response has arrived, then
    // SETTLE_CYCLES more so that the block is surely idle.
    task automatic settle();
        @(negedge clk);
        req_if.valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // The threshold register is written only while the block is idle.
    task automatic write_split_at(input split_t v);
        settle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        split_cfg = v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Directed rows. These all run right after reset with the default
    // threshold and a table far from full, so every key is simply stored and
    // echoed once with moved low and last high. They cover the key extremes,
    // equal keys, keys that differ only in one half, and zero-padded strings.
    plan_row_t directed_rows [16] = '{
        '{{64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000}, 1'b1, STORED, 1'b1},
        '{{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b1, STORED, 1'b1},
        '{{64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000}, 1'b1, STORED, 1'b1},
        '{{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b1, STORED, 1'b1},
        '{{64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b1, STORED, 1'b1},
        '{{64'h0000_0000_0000_0001, 64'h0000_0000_0000_0000}, 1'b1, STORED, 1'b1},
        '{{64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000}, 1'b1, STORED, 1'b1},
        '{{64'h8000_0000_0000_0000, 64'h0000_0000_0000_0000}, 1'b1, STORED, 1'b1},
        '{{64'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b1, STORED, 1'b1},
        '{{64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555}, 1'b0, STORED, 1'b1},
        '{{64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA}, 1'b0, STORED, 1'b1},
        '{{64'h6170_706C_6500_0000, 64'h0000_0000_0000_0000}, 1'b1, STORED, 1'b1},
        '{{64'h6170_706C_6573_0000, 64'h0000_0000_0000_0000}, 1'b1, STORED, 1'b1},
        '{{64'h6170_706C_6500_0000, 64'h0000_0000_0000_0000}, 1'b1, STORED, 1'b1},
        '{{64'h0000_0000_0000_0000, 64'h0000_0000_0000_0001}, 1'b1, STORED, 1'b1},
        '{{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE}, 1'b1, STORED, 1'b1}
    };

    initial
    begin
        // Every input is known from time zero. Reset is applied once, here.
        rst_n           = 1'b0;
        req_if.valid    = 1'b0;
        req_if.key_high = '0;
        req_if.key_low  = '0;
        rsp_if.ready    = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        idling          = 1'b1;
        table_count     = 0;
        split_cfg       = SPLIT_RESET;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            send_key(directed_rows[i].key, directed_rows[i].typed,
                     directed_rows[i].exp_moved, directed_rows[i].exp_last);

        // Fill the table to the reset threshold of 64. The last requests of
        // this phase cause the first split, with a full run of 32 moved entries.
        send_random(52);

        // A threshold of zero clamps up to one above the kept part. Nearly
        // every request now splits off one entry, or lets the key pass through.
        write_split_at(SPLIT_W'(0));
        send_random(30);

        // All ones clamps down to the capacity, so the table fills again.
        write_split_at(SPLIT_W'(127));
        send_random(40);

        // A threshold in range.
        write_split_at(SPLIT_W'(40));
        send_random(30);

        // The lowest valid threshold, with both sides running flat out.
        write_split_at(SPLIT_W'(KEEP + 1));
        idling = 1'b0;
        send_random(25);

        settle();
        repeat (20) @(posedge clk);

        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
